// ===== design/matrix_keypad_scanner_defines.svh =====
// Assertion macros shared by the keypad scanner RTL.
`ifndef MATRIX_KEYPAD_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define MKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad scanner assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner assertion failed");

`else

`define MKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/mks_pkg.sv =====
// Types and constants of the keypad scanner.
`default_nettype none

package mks_pkg;

    localparam int unsigned ROW_W   = 2;
    localparam int unsigned LINES_W = 4;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [LINES_W-1:0]   t_lines;
    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [CFG_W-1:0]     t_cfg_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_CHARS_ROW0 = 2'd0;
    localparam t_cfg_idx CFG_CHARS_ROW1 = 2'd1;
    localparam t_cfg_idx CFG_CHARS_ROW2 = 2'd2;
    localparam t_cfg_idx CFG_CHARS_ROW3 = 2'd3;

    // Default character table "123a456b789c*0#d", lowest key in the low byte.
    localparam t_cfg_word CHARS_ROW0_RST = 32'h6133_3231;
    localparam t_cfg_word CHARS_ROW1_RST = 32'h6236_3534;
    localparam t_cfg_word CHARS_ROW2_RST = 32'h6339_3837;
    localparam t_cfg_word CHARS_ROW3_RST = 32'h6423_302A;

    localparam t_char NO_KEY = 8'h00;

endpackage

`default_nettype wire

// ===== design/matrix_keypad_scanner.sv =====
// Top level of the 4x4 matrix keypad scanner.
//
// Each input beat carries the active-low return lines sampled while the current
// row was driven low; each beat yields exactly one output beat with the scanned
// row, the row to drive next, the key event and the held character. A beat is
// registered on entry, walked across the return columns combinationally, and
// registered at the output; one beat is taken every cycle while the output is
// not stalled. The throughput is set by the single compare chain over the
// return columns, which also updates the row index and the held character for
// the next beat. The user must write the character table through the
// configuration port only while the block is idle; the block does not enforce it.
`default_nettype none
`include "matrix_keypad_scanner_defines.svh"

module matrix_keypad_scanner #(
    parameter int unsigned SCAN_ROWS   = 4,
    parameter int unsigned RETURN_COLS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Character table write port.
    input  wire logic               i_cfg_we,
    input  wire mks_pkg::t_cfg_idx  i_cfg_index,
    input  wire mks_pkg::t_cfg_word i_cfg_data,
    // Row sample stream.
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,  // [3:0] return_lines
    // Scan result stream.
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [23:0]             m_axis_tdata,  // [1:0] scanned_row, [3:2] next_row,
                                                   // [11:4] event_char,
                                                   // [19:12] held_key_char
    output logic                    m_axis_tuser   // key_event
);

    import mks_pkg::*;

    localparam t_row LAST_ROW = ROW_W'(SCAN_ROWS - 1);

    t_cfg_word r_chars [4];
    t_row      r_row;
    t_char     r_held;

    logic      r_in_valid;
    t_lines    r_in_lines;

    logic      r_out_valid;
    t_row      r_out_scanned;
    t_row      r_out_next;
    logic      r_out_event;
    t_char     r_out_event_char;
    t_char     r_out_held;

    logic      move;
    t_cfg_word row_chars;
    t_char     key_char;
    t_char     n_held;
    logic      n_event;
    t_char     n_event_char;
    t_row      n_row;

    // The entry stage moves on when the output register is empty or being drained.
    assign move          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars[CFG_CHARS_ROW0] <= CHARS_ROW0_RST;
            r_chars[CFG_CHARS_ROW1] <= CHARS_ROW1_RST;
            r_chars[CFG_CHARS_ROW2] <= CHARS_ROW2_RST;
            r_chars[CFG_CHARS_ROW3] <= CHARS_ROW3_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHARS_ROW0: r_chars[CFG_CHARS_ROW0] <= i_cfg_data;
                CFG_CHARS_ROW1: r_chars[CFG_CHARS_ROW1] <= i_cfg_data;
                CFG_CHARS_ROW2: r_chars[CFG_CHARS_ROW2] <= i_cfg_data;
                CFG_CHARS_ROW3: r_chars[CFG_CHARS_ROW3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign row_chars = r_chars[r_row];

    // Walk the return columns in order; a later column sees the earlier updates.
    always_comb begin
        n_held       = r_held;
        n_event      = 1'b0;
        n_event_char = NO_KEY;
        key_char     = NO_KEY;
        for (int c = 0; c < 4; c++) begin
            if (c < RETURN_COLS) begin
                key_char = row_chars[CHAR_W*c +: CHAR_W];
                if (!r_in_lines[c]) begin
                    if (n_held == NO_KEY) begin
                        n_held = key_char;
                        if (key_char != NO_KEY) begin
                            n_event      = 1'b1;
                            n_event_char = key_char;
                        end
                    end
                end else if (n_held == key_char) begin
                    n_held = NO_KEY;
                end
            end
        end
    end

    assign n_row = (r_row >= LAST_ROW) ? '0 : r_row + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_held      <= NO_KEY;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_row       <= n_row;
                r_held      <= n_held;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_lines <= s_axis_tdata[LINES_W-1:0];
        end
        if (move) begin
            r_out_scanned    <= r_row;
            r_out_next       <= n_row;
            r_out_event      <= n_event;
            r_out_event_char <= n_event_char;
            r_out_held       <= n_held;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_event;
    assign m_axis_tdata  = {4'b0000, r_out_held, r_out_event_char, r_out_next, r_out_scanned};

    `MKS_ASSERT_NOW(a_event_has_char, i_clk, i_rst_n,
        r_out_valid && r_out_event, r_out_event_char != NO_KEY)
    `MKS_ASSERT_NOW(a_no_event_no_char, i_clk, i_rst_n,
        r_out_valid && !r_out_event, r_out_event_char == NO_KEY)
    `MKS_ASSERT_NEXT(a_state_matches_result, i_clk, i_rst_n,
        move, r_held == r_out_held && r_row == r_out_next)
    `MKS_ASSERT_NOW(a_stall_holds_entry, i_clk, i_rst_n,
        !s_axis_tready, r_in_valid && r_out_valid)

endmodule

`default_nettype wire
